// ----- design/fip_pkg.sv -----
// ----------------------------------------------------------------------------
// fip_pkg
// Shared types and constants for the double-precision integer power block:
// input and result words, the arithmetic unit request and response words.
// ----------------------------------------------------------------------------
package fip_pkg;

	// ieee-754 double constants
	localparam logic [63:0] ONE_BITS  = 64'h3FF0_0000_0000_0000;
	localparam logic [63:0] ZERO_BITS = 64'h0000_0000_0000_0000;
	// default quiet nan produced by invalid operations
	localparam logic [63:0] QNAN_DFLT = 64'hFFF8_0000_0000_0000;

	// input word
	typedef struct packed {
		logic [63:0]        base_bits;
		logic signed [31:0] exponent;
	} in_word_t;

	// result word
	typedef struct packed {
		logic [63:0] result_bits;
		logic        divide_by_zero;
	} out_word_t;

	// arithmetic unit operations
	typedef enum logic [1:0] {
		FOP_MUL = 2'b01,
		FOP_RCP = 2'b10
	} fpu_op_t;

	// request to the arithmetic unit: a*b, or 1/a
	typedef struct packed {
		logic        start;
		fpu_op_t     op;
		logic [63:0] a;
		logic [63:0] b;
	} fpu_req_t;

	// response from the arithmetic unit
	typedef struct packed {
		logic        done;
		logic [63:0] z;
	} fpu_rsp_t;

endpackage

// ----- design/fip_fpu.sv -----
// ----------------------------------------------------------------------------
// fip_fpu
// Iterative double-precision unit: multiply (four 27x27 partial products)
// or reciprocal (restoring division, one quotient bit per cycle), followed
// by a shared bit-serial normalize, denormalize and round-to-nearest-even.
// ----------------------------------------------------------------------------
module fip_fpu (
	input  logic               clk,
	input  logic               arst_n,
	input  fip_pkg::fpu_req_t  req,
	output fip_pkg::fpu_rsp_t  rsp
);

	typedef enum logic [6:0] {
		F_IDLE   = 7'b0000001,
		F_MUL    = 7'b0000010,
		F_DNORM  = 7'b0000100,
		F_DIV    = 7'b0001000,
		F_NORM   = 7'b0010000,
		F_DENORM = 7'b0100000,
		F_ROUND  = 7'b1000000
	} fstate_t;

	fstate_t            state_q;
	logic [52:0]        ma_q;
	logic [52:0]        mb_q;
	logic [1:0]         pp_cnt_q;
	logic [105:0]       mant_q;
	logic signed [12:0] be_q;
	logic               stk_q;
	logic               sgn_q;
	logic [53:0]        rem_q;
	logic [57:0]        quo_q;
	logic [5:0]         div_cnt_q;
	logic               done_q;
	logic [63:0]        z_q;

	// operand unpack
	logic [10:0] ea, eb;
	logic [51:0] fa, fb;
	logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
	logic [52:0] ma_un, mb_un;
	logic [10:0] ea_eff, eb_eff;

	always_comb begin
		ea     = req.a[62:52];
		eb     = req.b[62:52];
		fa     = req.a[51:0];
		fb     = req.b[51:0];
		a_nan  = (ea == 11'h7FF) && (fa != 52'd0);
		b_nan  = (eb == 11'h7FF) && (fb != 52'd0);
		a_inf  = (ea == 11'h7FF) && (fa == 52'd0);
		b_inf  = (eb == 11'h7FF) && (fb == 52'd0);
		a_zero = (req.a[62:0] == 63'd0);
		b_zero = (req.b[62:0] == 63'd0);
		ma_un  = {(ea != 11'd0), fa};
		mb_un  = {(eb != 11'd0), fb};
		ea_eff = (ea == 11'd0) ? 11'd1 : ea;
		eb_eff = (eb == 11'd0) ? 11'd1 : eb;
	end

	// one 27x27 partial product per cycle
	logic [26:0]  pa, pb;
	logic [53:0]  pp;
	logic [105:0] pp_sh;

	always_comb begin
		pa = pp_cnt_q[1] ? {1'b0, ma_q[52:27]} : ma_q[26:0];
		pb = pp_cnt_q[0] ? {1'b0, mb_q[52:27]} : mb_q[26:0];
		pp = pa * pb;
		case (pp_cnt_q)
			2'd0:    pp_sh = {52'd0, pp};
			2'd3:    pp_sh = {pp[51:0], 54'd0};
			default: pp_sh = {25'd0, pp, 27'd0};
		endcase
	end

	// one restoring division step
	logic        div_ge;
	logic [53:0] div_diff;
	logic [57:0] quo_n;

	always_comb begin
		div_ge   = rem_q >= {1'b0, mb_q};
		div_diff = div_ge ? (rem_q - {1'b0, mb_q}) : rem_q;
		quo_n    = {quo_q[56:0], div_ge};
	end

	// round to nearest even and pack
	logic [52:0]        m53;
	logic               rnd_g, rnd_s, rnd_inc, rnd_carry;
	logic [53:0]        rnd_sum;
	logic [52:0]        mfin;
	logic signed [12:0] be2;
	logic [10:0]        expf;
	logic [63:0]        round_z;

	always_comb begin
		m53       = mant_q[105:53];
		rnd_g     = mant_q[52];
		rnd_s     = (|mant_q[51:0]) | stk_q;
		rnd_inc   = rnd_g & (rnd_s | m53[0]);
		rnd_sum   = {1'b0, m53} + {53'd0, rnd_inc};
		rnd_carry = rnd_sum[53];
		mfin      = rnd_carry ? rnd_sum[53:1] : rnd_sum[52:0];
		be2       = be_q + (rnd_carry ? 13'sd1 : 13'sd0);
		expf      = mfin[52] ? be2[10:0] : 11'd0;
		if (be2 > 13'sd2046) begin
			round_z = {sgn_q, 11'h7FF, 52'd0};
		end else begin
			round_z = {sgn_q, expf, mfin[51:0]};
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				F_IDLE: begin
					if (req.start) begin
						if (req.op == fip_pkg::FOP_MUL) begin
							sgn_q <= req.a[63] ^ req.b[63];
							if (a_nan) begin
								z_q    <= req.a | 64'h0008_0000_0000_0000;
								done_q <= 1'b1;
							end else if (b_nan) begin
								z_q    <= req.b | 64'h0008_0000_0000_0000;
								done_q <= 1'b1;
							end else if ((a_inf && b_zero) || (b_inf && a_zero)) begin
								z_q    <= fip_pkg::QNAN_DFLT;
								done_q <= 1'b1;
							end else if (a_inf || b_inf) begin
								z_q    <= {req.a[63] ^ req.b[63], 11'h7FF, 52'd0};
								done_q <= 1'b1;
							end else if (a_zero || b_zero) begin
								z_q    <= {req.a[63] ^ req.b[63], 63'd0};
								done_q <= 1'b1;
							end else begin
								ma_q     <= ma_un;
								mb_q     <= mb_un;
								mant_q   <= '0;
								stk_q    <= 1'b0;
								pp_cnt_q <= 2'd0;
								be_q     <= $signed({2'b00, ea_eff}) + $signed({2'b00, eb_eff})
									- 13'sd1022;
								state_q  <= F_MUL;
							end
						end else begin
							sgn_q <= req.a[63];
							if (a_nan) begin
								z_q    <= req.a | 64'h0008_0000_0000_0000;
								done_q <= 1'b1;
							end else if (a_inf) begin
								z_q    <= {req.a[63], 63'd0};
								done_q <= 1'b1;
							end else begin
								mb_q    <= ma_un;
								be_q    <= $signed({2'b00, ea_eff});
								stk_q   <= 1'b0;
								state_q <= F_DNORM;
							end
						end
					end
				end
				F_MUL: begin
					mant_q   <= mant_q + pp_sh;
					pp_cnt_q <= pp_cnt_q + 2'd1;
					if (pp_cnt_q == 2'd3) begin
						state_q <= F_NORM;
					end
				end
				F_DNORM: begin
					// bring a subnormal divisor to full width
					if (!mb_q[52]) begin
						mb_q <= {mb_q[51:0], 1'b0};
						be_q <= be_q - 13'sd1;
					end else begin
						be_q      <= 13'sd2046 - be_q;
						rem_q     <= 54'd1 << 52;
						quo_q     <= '0;
						div_cnt_q <= 6'd0;
						state_q   <= F_DIV;
					end
				end
				F_DIV: begin
					quo_q     <= quo_n;
					rem_q     <= {div_diff[52:0], 1'b0};
					div_cnt_q <= div_cnt_q + 6'd1;
					if (div_cnt_q == 6'd57) begin
						mant_q  <= {quo_n, 48'd0};
						stk_q   <= (div_diff != 54'd0);
						state_q <= F_NORM;
					end
				end
				F_NORM: begin
					if (!mant_q[105]) begin
						mant_q <= {mant_q[104:0], 1'b0};
						be_q   <= be_q - 13'sd1;
					end else begin
						state_q <= F_DENORM;
					end
				end
				F_DENORM: begin
					// shift into the subnormal range, collecting sticky bits
					if (be_q < 13'sd1) begin
						if (mant_q != 106'd0) begin
							mant_q <= {1'b0, mant_q[105:1]};
							stk_q  <= stk_q | mant_q[0];
							be_q   <= be_q + 13'sd1;
						end else begin
							be_q <= 13'sd1;
						end
					end else begin
						state_q <= F_ROUND;
					end
				end
				F_ROUND: begin
					z_q     <= round_z;
					done_q  <= 1'b1;
					state_q <= F_IDLE;
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	assign rsp.done = done_q;
	assign rsp.z    = z_q;

endmodule

// ----- design/float_integer_power.sv -----
// ----------------------------------------------------------------------------
// float_integer_power
// Raises an IEEE-754 double base to a signed 32-bit integer power with
// bit-exact round-to-nearest-even results, by repeated squaring.
// ----------------------------------------------------------------------------
// One word is handled at a time; in_ready is low from acceptance until the
// result word has been taken. A zero exponent or a zero base is answered in
// the cycle after acceptance. Otherwise all arithmetic runs through a single
// iterative double unit: each multiply is 4 partial products plus normalize
// and round, and subnormal results must also be normalized and then shifted
// back down; a negative exponent first takes a reciprocal. An exponent of
// magnitude p needs up to 2*floor(log2 p) multiplies.
// A zero base with a negative exponent raises divide_by_zero with a zero
// result.
module float_integer_power (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  fip_pkg::in_word_t   in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output fip_pkg::out_word_t  out_data
);

	typedef enum logic [4:0] {
		T_IDLE  = 5'b00001,
		T_SCAN  = 5'b00010,
		T_WAIT  = 5'b00100,
		T_LEVEL = 5'b01000,
		T_OUT   = 5'b10000
	} tstate_t;

	typedef enum logic [4:0] {
		PH_RECIP = 5'b00001,
		PH_BASE1 = 5'b00010,
		PH_BASE2 = 5'b00100,
		PH_LVL1  = 5'b01000,
		PH_LVL2  = 5'b10000
	} phase_t;

	tstate_t            state_q;
	phase_t             ph_q;
	fip_pkg::fpu_req_t  req_q;
	fip_pkg::fpu_rsp_t  fpu_rsp;
	fip_pkg::out_word_t out_q;
	logic [63:0]        b_q;
	logic [63:0]        r_q;
	logic [31:0]        mag_q;
	logic [31:0]        sh_q;
	logic [4:0]         lvl_q;

	// input decode
	logic        in_acc;
	logic        in_neg;
	logic [31:0] e_u;
	logic [31:0] in_mag;
	logic        cur_bit;
	logic [63:0] z;

	always_comb begin
		in_acc  = in_valid && in_ready;
		e_u     = in_data.exponent;
		in_neg  = e_u[31];
		in_mag  = in_neg ? (32'd0 - e_u) : e_u;
		cur_bit = mag_q[lvl_q - 5'd1];
		z       = fpu_rsp.z;
	end

	// shared arithmetic unit
	fip_fpu u_fpu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_q),
		.rsp    (fpu_rsp)
	);

	// power sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= T_IDLE;
			req_q.start <= 1'b0;
		end else begin
			req_q.start <= 1'b0;
			unique case (state_q)
				T_IDLE: begin
					if (in_acc) begin
						mag_q <= in_mag;
						if (e_u == 32'd0) begin
							out_q   <= '{result_bits: fip_pkg::ONE_BITS, divide_by_zero: 1'b0};
							state_q <= T_OUT;
						end else if (in_data.base_bits[62:0] == 63'd0) begin
							out_q   <= '{result_bits: fip_pkg::ZERO_BITS,
								divide_by_zero: in_neg};
							state_q <= T_OUT;
						end else if (in_neg) begin
							req_q.start <= 1'b1;
							req_q.op    <= fip_pkg::FOP_RCP;
							req_q.a     <= in_data.base_bits;
							req_q.b     <= in_data.base_bits;
							ph_q        <= PH_RECIP;
							state_q     <= T_WAIT;
						end else begin
							b_q     <= in_data.base_bits;
							sh_q    <= in_mag;
							lvl_q   <= 5'd0;
							state_q <= T_SCAN;
						end
					end
				end
				T_SCAN: begin
					// halve the power until it is at most four
					if (sh_q > 32'd4) begin
						sh_q  <= {1'b0, sh_q[31:1]};
						lvl_q <= lvl_q + 5'd1;
					end else if (sh_q[2:0] == 3'd1) begin
						r_q     <= b_q;
						state_q <= T_LEVEL;
					end else begin
						req_q.start <= 1'b1;
						req_q.op    <= fip_pkg::FOP_MUL;
						req_q.a     <= b_q;
						req_q.b     <= b_q;
						ph_q        <= PH_BASE1;
						state_q     <= T_WAIT;
					end
				end
				T_WAIT: begin
					if (fpu_rsp.done) begin
						unique case (ph_q)
							PH_RECIP: begin
								if (z[62:0] == 63'd0) begin
									out_q   <= '{result_bits: fip_pkg::ZERO_BITS,
										divide_by_zero: 1'b0};
									state_q <= T_OUT;
								end else begin
									b_q     <= z;
									sh_q    <= mag_q;
									lvl_q   <= 5'd0;
									state_q <= T_SCAN;
								end
							end
							PH_BASE1: begin
								if (sh_q[2:0] == 3'd2) begin
									r_q     <= z;
									state_q <= T_LEVEL;
								end else begin
									req_q.start <= 1'b1;
									req_q.op    <= fip_pkg::FOP_MUL;
									req_q.a     <= z;
									req_q.b     <= (sh_q[2:0] == 3'd3) ? b_q : z;
									ph_q        <= PH_BASE2;
								end
							end
							PH_BASE2: begin
								r_q     <= z;
								state_q <= T_LEVEL;
							end
							PH_LVL1: begin
								if (cur_bit) begin
									req_q.start <= 1'b1;
									req_q.op    <= fip_pkg::FOP_MUL;
									req_q.a     <= z;
									req_q.b     <= r_q;
									ph_q        <= PH_LVL2;
								end else begin
									r_q     <= z;
									lvl_q   <= lvl_q - 5'd1;
									state_q <= T_LEVEL;
								end
							end
							PH_LVL2: begin
								r_q     <= z;
								lvl_q   <= lvl_q - 5'd1;
								state_q <= T_LEVEL;
							end
							default: state_q <= T_IDLE;
						endcase
					end
				end
				T_LEVEL: begin
					// one squaring level per pass, levels with an odd power multiply by the base first
					if (lvl_q == 5'd0) begin
						out_q   <= '{result_bits: r_q, divide_by_zero: 1'b0};
						state_q <= T_OUT;
					end else begin
						req_q.start <= 1'b1;
						req_q.op    <= fip_pkg::FOP_MUL;
						req_q.a     <= cur_bit ? b_q : r_q;
						req_q.b     <= r_q;
						ph_q        <= PH_LVL1;
						state_q     <= T_WAIT;
					end
				end
				T_OUT: begin
					if (out_ready) begin
						state_q <= T_IDLE;
					end
				end
				default: state_q <= T_IDLE;
			endcase
		end
	end

	assign in_ready  = (state_q == T_IDLE);
	assign out_valid = (state_q == T_OUT);
	assign out_data  = out_q;

`ifndef SYNTHESIS
	// a zero exponent answers 1.0 on the next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && in_data.exponent == 32'sd0) |=>
			(out_valid && out_data.result_bits == fip_pkg::ONE_BITS))
		else $error("zero exponent did not give 1.0");

	// a divide by zero flag always comes with a zero result
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.divide_by_zero) |-> (out_data.result_bits == 64'd0))
		else $error("divide by zero with nonzero result");

	// the arithmetic unit only answers while the sequencer waits for it
	assert property (@(posedge clk) disable iff (!arst_n)
		fpu_rsp.done |-> (state_q == T_WAIT))
		else $error("arithmetic result arrived outside wait state");
`endif

endmodule

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for float_integer_power: streams double bases and signed
// exponents through the valid/ready input with random gaps, predicts each
// result word with the simulator's double arithmetic in the same operation
// order as the block, and checks every result word in order, with random
// stalls on the result side.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int  N_RANDOM  = 1400;
	localparam int  MAX_CYC   = 100000000;
	localparam int  DRAIN_CYC = 700;
	localparam logic [63:0] INF_BITS  = 64'h7FF0_0000_0000_0000;
	localparam logic [63:0] NZERO_BITS = 64'h8000_0000_0000_0000;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	fip_pkg::in_word_t  in_data;
	logic               out_valid;
	logic               out_ready;
	fip_pkg::out_word_t out_data;

	fip_pkg::in_word_t  pending_words[$];
	fip_pkg::out_word_t expected_words[$];
	logic      in_taken;
	logic      out_taken;
	int        in_gap;
	int        out_stall;
	bit        idle_on;
	int        cycle_cnt;
	int        fail_cnt;

	float_integer_power u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	// clock
	initial clk = 1'b0;
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// fixed forms up to power 4, recursive halving above
	function automatic real pow_halving(real b, int unsigned p);
		real r;
		if (p == 1) return b;
		if (p == 2) return b * b;
		if (p == 3) return (b * b) * b;
		if (p == 4) return (b * b) * (b * b);
		r = pow_halving(b, p >> 1);
		if (p[0]) return (b * r) * r;
		return r * r;
	endfunction

	// expected result word for one input word
	function automatic fip_pkg::out_word_t predict_power(fip_pkg::in_word_t w);
		fip_pkg::out_word_t o;
		real         base;
		real         start;
		int unsigned mag;
		base = $bitstoreal(w.base_bits);
		o.divide_by_zero = 1'b0;
		if (w.exponent == 0) begin
			o.result_bits = fip_pkg::ONE_BITS;
		end else if (base == 0.0) begin
			o.result_bits    = fip_pkg::ZERO_BITS;
			o.divide_by_zero = w.exponent < 0;
		end else begin
			if (w.exponent < 0) begin
				start = 1.0 / base;
				mag   = ~w.exponent + 1;
			end else begin
				start = base;
				mag   = w.exponent;
			end
			if (start == 0.0) o.result_bits = fip_pkg::ZERO_BITS;
			else              o.result_bits = $realtobits(pow_halving(start, mag));
		end
		return o;
	endfunction

	function automatic fip_pkg::in_word_t mk(logic [63:0] b, int e);
		fip_pkg::in_word_t w;
		w.base_bits = b;
		w.exponent  = e;
		return w;
	endfunction

	// random word: mostly bases near one and small powers
	function automatic fip_pkg::in_word_t rand_word();
		logic [63:0] b;
		int          e;
		int          sel;
		b   = {$urandom, $urandom};
		sel = $urandom_range(0, 9);
		if (sel < 7) b[62:52] = 11'($urandom_range(11'h3F0, 11'h40F));
		sel = $urandom_range(0, 9);
		if (sel < 6)      e = $signed($urandom_range(0, 80)) - 40;
		else if (sel < 8) e = $signed($urandom_range(0, 4000)) - 2000;
		else              e = $urandom;
		if ($urandom_range(0, 49) == 0) e = 0;
		if ($urandom_range(0, 49) == 0) b[62:0] = '0;
		return mk(b, e);
	endfunction

	// input driver, changes on the falling edge
	always @(negedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_taken) begin
				// hold word until accepted
			end else if (in_gap > 0) begin
				in_valid <= 1'b0;
				in_gap   <= in_gap - 1;
			end else if (pending_words.size() > 0) begin
				in_valid <= 1'b1;
				in_data  <= pending_words.pop_front();
				in_gap   <= idle_on ? $urandom_range(0, 3) : 0;
			end else begin
				in_valid <= 1'b0;
			end
			// result side stall
			if (out_taken) begin
				out_stall <= idle_on ? $urandom_range(0, 3) : 0;
				out_ready <= 1'b0;
			end else if (out_stall > 0) begin
				out_stall <= out_stall - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// monitor on the rising edge
	always @(posedge clk) begin
		fip_pkg::out_word_t e;
		cycle_cnt <= cycle_cnt + 1;
		in_taken  <= in_valid && in_ready;
		out_taken <= out_valid && out_ready;
		if (in_valid && in_ready) expected_words.push_back(predict_power(in_data));
		if (out_valid && out_ready) begin
			if (expected_words.size() == 0) begin
				$error("result word with nothing expected");
				fail_cnt <= fail_cnt + 1;
			end else begin
				e = expected_words.pop_front();
				if (out_data.result_bits !== e.result_bits) begin
					$error("result_bits expected %h actual %h", e.result_bits,
						out_data.result_bits);
					fail_cnt <= fail_cnt + 1;
				end
				if (out_data.divide_by_zero !== e.divide_by_zero) begin
					$error("divide_by_zero expected %b actual %b", e.divide_by_zero,
						out_data.divide_by_zero);
					fail_cnt <= fail_cnt + 1;
				end
			end
		end
		if (cycle_cnt > MAX_CYC) begin
			$display("float_integer_power verification failed");
			$finish;
		end
	end

	// stimulus and end of run
	initial begin
		int i;
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		in_data   = '0;
		out_ready = 1'b0;
		in_taken  = 1'b0;
		out_taken = 1'b0;
		in_gap    = 0;
		out_stall = 0;
		idle_on   = 1'b1;
		cycle_cnt = 0;
		fail_cnt  = 0;

		// directed words: zero power, zero bases, infinite base, extremes
		pending_words.push_back(mk(fip_pkg::ZERO_BITS, 0));
		pending_words.push_back(mk(INF_BITS, 0));
		pending_words.push_back(mk(fip_pkg::QNAN_DFLT, 0));
		pending_words.push_back(mk(fip_pkg::ZERO_BITS, 5));
		pending_words.push_back(mk(NZERO_BITS, 3));
		pending_words.push_back(mk(fip_pkg::ZERO_BITS, -1));
		pending_words.push_back(mk(NZERO_BITS, 32'h8000_0000));
		pending_words.push_back(mk(INF_BITS, -3));
		pending_words.push_back(mk(INF_BITS | NZERO_BITS, -2));
		pending_words.push_back(mk(INF_BITS, 7));
		pending_words.push_back(mk(64'hBFF0_0000_0000_0001, 32'h8000_0000));
		pending_words.push_back(mk(64'h3FF0_0000_0000_0001, 32'h7FFF_FFFF));
		pending_words.push_back(mk(64'hC000_0000_0000_0000, 1));
		pending_words.push_back(mk(64'hC000_0000_0000_0000, 2));
		pending_words.push_back(mk(64'h4008_0000_0000_0000, 3));
		pending_words.push_back(mk(64'h4008_0000_0000_0000, 4));
		pending_words.push_back(mk(64'h3FF8_0000_0000_0000, 5));
		pending_words.push_back(mk(64'h3FF8_0000_0000_0000, -6));
		pending_words.push_back(mk(64'h7FEF_FFFF_FFFF_FFFF, 2));
		pending_words.push_back(mk(64'h0000_0000_0000_0001, 1));
		pending_words.push_back(mk(64'h0000_0000_0000_0001, -1));
		pending_words.push_back(mk(64'h000F_FFFF_FFFF_FFFF, 3));
		pending_words.push_back(mk(64'hFFFF_FFFF_FFFF_FFFF, 9));
		pending_words.push_back(mk(64'h3FE0_0000_0000_0000, 1100));
		for (i = 0; i < N_RANDOM; i++) pending_words.push_back(rand_word());

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// switch idling off for stretches
		while (pending_words.size() > 0 || in_valid) begin
			repeat (300) @(posedge clk);
			idle_on = ($urandom_range(0, 3) != 0);
		end
		while (expected_words.size() > 0) @(posedge clk);
		repeat (DRAIN_CYC) @(posedge clk);
		if (fail_cnt == 0 && expected_words.size() == 0) begin
			$display("float_integer_power verification clean");
		end else begin
			$display("float_integer_power verification failed");
		end
		$finish;
	end

endmodule

// ----- float_integer_power.f -----
design/fip_pkg.sv
design/fip_fpu.sv
design/float_integer_power.sv
tb/tb_top.sv
